FILE: src/rirb_pkg.sv
package rirb_pkg;

  localparam int STORE_PIXELS = 131072;
  localparam int STORE_AW     = $clog2(STORE_PIXELS);
  localparam int COORD_BITS   = 10;
  localparam int INDEX_BITS   = 17;
  localparam int COLOR_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int SRC_BITS     = 2 * COORD_BITS + 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = QPTR_BITS + 1;

  localparam logic [COORD_BITS-1:0] RESET_IMAGE_WIDTH      = COORD_BITS'(240);
  localparam logic [COORD_BITS-1:0] RESET_IMAGE_HEIGHT     = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] RESET_PANEL_HORIZONTAL = COORD_BITS'(240);
  localparam logic [COORD_BITS-1:0] RESET_PANEL_VERTICAL   = COORD_BITS'(320);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_PANEL_HORIZONTAL,
    REG_PANEL_VERTICAL
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_t;

  typedef struct packed {
    logic                  req_type;
    logic [INDEX_BITS-1:0] load_index;
    logic [COLOR_BITS-1:0] load_color;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COLOR_BITS-1:0] panel_color;
    logic                  end_of_row;
    logic                  end_of_frame;
    logic                  range_error;
  } out_word_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic                   is_step;
    logic [INDEX_BITS-1:0]  load_index;
    logic [COLOR_BITS-1:0]  load_color;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [COORD_BITS-1:0]  sx;
    logic signed [COORD_BITS:0] sy;
    logic                   eor;
    logic                   eof;
  } cmd_t;

  function automatic logic [COLOR_BITS-1:0] swap_red_blue(input logic [COLOR_BITS-1:0] c);
    return {c[4:0], c[10:5], c[15:11]};
  endfunction

endpackage

FILE: src/rgb565_image_rotate_blit_top.sv
// RGB565 image store and panel pixel streamer.
// Input queue (in_push/in_full, in_data): a load word writes one source
// pixel into the image store and gives no result; a step word produces the
// next panel pixel in raster order, with position, end-of-row/end-of-frame
// marks and red/blue swapped color. When the image is panel_vertical wide
// and panel_horizontal tall, the image is read rotated by a quarter turn.
// Result queue (out_empty/out_pop, out_data): oldest pixel is shown while
// out_empty is low. Config port (cfg_we, cfg_index, cfg_data) writes one of
// the four size registers per cycle; write only while the block is idle.
// Throughput: one word per cycle while the result queue has room, set by the
// single store port that serves one load write or one step read each cycle.
// A step word passes through the command queue, the multiply register, the
// store read and the result queue write before it shows on the result side.
// Reset clears both queues, the position counters and restores the size
// registers; the store contents are kept and need no clearing.
// When the receiver stalls, the four-entry result queue fills, the back
// end stops taking words and the four-entry command queue raises in_full.
module rgb565_image_rotate_blit_top
  import rirb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  in_word_t                in_data,
  output logic                    in_full,
  output logic                    out_empty,
  output out_word_t               out_data,
  input  logic                    out_pop,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  logic [COORD_BITS-1:0] image_width;
  logic                  cmd_valid, cmd_pop;
  cmd_t                  cmd_head;

  rirb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .image_width (image_width),
    .cmd_valid   (cmd_valid),
    .cmd_head    (cmd_head),
    .cmd_pop     (cmd_pop)
  );

  rirb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_width (image_width),
    .cmd_valid   (cmd_valid),
    .cmd_head    (cmd_head),
    .cmd_pop     (cmd_pop),
    .out_empty   (out_empty),
    .out_data    (out_data),
    .out_pop     (out_pop)
  );

endmodule

FILE: src/rirb_front.sv
module rirb_front
  import rirb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  in_word_t                in_data,
  output logic                    in_full,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  output logic [COORD_BITS-1:0]   image_width,
  output logic                    cmd_valid,
  output cmd_t                    cmd_head,
  input  logic                    cmd_pop
);

  logic [COORD_BITS-1:0] width_r, height_r, panel_h_r, panel_v_r;
  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;

  cmd_t                  q_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  logic                  push, rot;
  logic [COORD_BITS-1:0] out_w, out_h;
  cmd_t                  cmd;

  assign in_full     = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign push        = in_push && !in_full;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd_head    = q_mem[rd_ptr_r];
  assign image_width = width_r;

  always_comb begin
    rot   = (width_r == panel_v_r) && (height_r == panel_h_r);
    out_w = rot ? height_r : width_r;
    out_h = rot ? width_r : height_r;

    cmd.is_step    = (in_data.req_type == REQ_STEP);
    cmd.load_index = in_data.load_index;
    cmd.load_color = in_data.load_color;
    cmd.x          = col_r;
    cmd.y          = row_r;
    cmd.eor        = ({1'b0, col_r} + (COORD_BITS+1)'(1)) >= {1'b0, out_w};
    cmd.eof        = cmd.eor && (({1'b0, row_r} + (COORD_BITS+1)'(1)) >= {1'b0, out_h});
    if (rot) begin
      cmd.sx = row_r;
      cmd.sy = $signed({1'b0, height_r}) - $signed((COORD_BITS+1)'(1)) - $signed({1'b0, col_r});
    end else begin
      cmd.sx = col_r;
      cmd.sy = $signed({1'b0, row_r});
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (push && cmd.is_step) begin
      priority if (cmd.eof) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (cmd.eor) begin
        col_nxt = '0;
        row_nxt = row_r + COORD_BITS'(1);
      end else begin
        col_nxt = col_r + COORD_BITS'(1);
      end
    end

    cnt_nxt = cnt_r + QCNT_BITS'(push) - QCNT_BITS'(cmd_pop && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RESET_IMAGE_WIDTH;
      height_r  <= RESET_IMAGE_HEIGHT;
      panel_h_r <= RESET_PANEL_HORIZONTAL;
      panel_v_r <= RESET_PANEL_VERTICAL;
      col_r     <= '0;
      row_r     <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:      width_r   <= cfg_data;
          REG_IMAGE_HEIGHT:     height_r  <= cfg_data;
          REG_PANEL_HORIZONTAL: panel_h_r <= cfg_data;
          REG_PANEL_VERTICAL:   panel_v_r <= cfg_data;
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: src/rirb_back.sv
module rirb_back
  import rirb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COORD_BITS-1:0] image_width,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd_head,
  output logic                  cmd_pop,
  output logic                  out_empty,
  output out_word_t             out_data,
  input  logic                  out_pop
);

  // Multiply stage
  logic                       s1_v_r;
  cmd_t                       s1_cmd_r;
  logic signed [SRC_BITS-1:0] s1_prod_r;

  // Store access stage
  logic                       s2_v_r;
  out_word_t                  s2_word_r;
  logic [COLOR_BITS-1:0]      mem_q_r;

  logic [COLOR_BITS-1:0]      pixel_store [STORE_PIXELS];

  out_word_t                  oq_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]       oq_wr_r, oq_rd_r;
  logic [QCNT_BITS-1:0]       oq_cnt_r;

  logic [QCNT_BITS:0]         committed;
  logic signed [SRC_BITS-1:0] prod, src;
  logic                       err, mem_we, mem_re;
  logic [STORE_AW-1:0]        addr;
  out_word_t                  s2_word, res;
  logic                       do_pop;

  // Reserve a result slot for every word that enters the pipe.
  assign committed = {1'b0, oq_cnt_r} + (QCNT_BITS+1)'(s1_v_r) + (QCNT_BITS+1)'(s2_v_r);
  assign cmd_pop   = cmd_valid && (committed < (QCNT_BITS+1)'(QUEUE_DEPTH));
  assign prod      = cmd_head.sy * $signed({1'b0, image_width});

  assign out_empty = (oq_cnt_r == '0);
  assign out_data  = oq_mem[oq_rd_r];
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    src = s1_prod_r + $signed({{(SRC_BITS-COORD_BITS){1'b0}}, s1_cmd_r.sx});
    err = src[SRC_BITS-1] || (src >= $signed(SRC_BITS'(STORE_PIXELS)));
    if (s1_cmd_r.is_step) begin
      addr = src[STORE_AW-1:0];
    end else begin
      addr = s1_cmd_r.load_index[STORE_AW-1:0];
    end
    mem_we = s1_v_r && !s1_cmd_r.is_step && (32'(s1_cmd_r.load_index) < STORE_PIXELS);
    mem_re = s1_v_r && s1_cmd_r.is_step && !err;

    s2_word.out_x        = s1_cmd_r.x;
    s2_word.out_y        = s1_cmd_r.y;
    s2_word.panel_color  = '0;
    s2_word.end_of_row   = s1_cmd_r.eor;
    s2_word.end_of_frame = s1_cmd_r.eof;
    s2_word.range_error  = err;

    res = s2_word_r;
    if (!s2_word_r.range_error) begin
      res.panel_color = swap_red_blue(mem_q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      s1_v_r   <= cmd_pop;
      // Loads end at the store write.
      s2_v_r   <= s1_v_r && s1_cmd_r.is_step;
      oq_cnt_r <= oq_cnt_r + QCNT_BITS'(s2_v_r) - QCNT_BITS'(do_pop);
      if (s2_v_r) begin
        oq_wr_r <= oq_wr_r + QPTR_BITS'(1);
      end
      if (do_pop) begin
        oq_rd_r <= oq_rd_r + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd_r  <= cmd_head;
      s1_prod_r <= prod;
    end
    if (s1_v_r) begin
      s2_word_r <= s2_word;
    end
    if (s2_v_r) begin
      oq_mem[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[addr] <= s1_cmd_r.load_color;
    end
    if (mem_re) begin
      mem_q_r <= pixel_store[addr];
    end
  end

endmodule

FILE: src/rirb_checker.sv
module rirb_checker
  import rirb_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_full,
  input logic                    out_empty,
  input out_word_t               out_data,
  input logic                    out_pop
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result word changed");

  a_frame_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !out_data.end_of_frame || out_data.end_of_row)
    else $error("end of frame without end of row");

  a_error_black: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.range_error |-> out_data.panel_color == '0)
    else $error("out of range pixel carries color");

endmodule

bind rgb565_image_rotate_blit_top rirb_checker u_rirb_checker (.*);
